/* src/qfct_pkg.sv */
// ----------------------------------------------------------------------------
// qfct_pkg
// Shared constants and types for the quadratic first crossing time block.
// ----------------------------------------------------------------------------
`default_nettype none

package qfct_pkg;

  // default data path shape (signed Qm.n)
  localparam int unsigned DATA_WIDTH_DEF  = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  // entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // how the root numerator is formed once the square root is known
  typedef enum logic [1:0] {
    SEL_LIN = 2'd0,  // linear equation: |k| / |b|
    SEL_SUB = 2'd1,  // smaller root:    (|b| - s) / 2a
    SEL_ADD = 2'd2,  // larger root:     (|b| + s) / 2a
    SEL_DIF = 2'd3   // larger root:     (s - |b|) / 2a
  } root_sel_e;

  // per-equation classification handed from front to back
  typedef struct packed {
    logic      ok;   // a positive root exists
    root_sel_e sel;
  } eq_ctl_t;

endpackage

`default_nettype wire

/* src/qfct_fifo.sv */
// ----------------------------------------------------------------------------
// qfct_fifo
// Small register queue that decouples the front and back sections.
// ----------------------------------------------------------------------------
`default_nettype none

module qfct_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = qfct_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* src/qfct_front.sv */
// ----------------------------------------------------------------------------
// qfct_front
// Accepts coefficients, normalizes signs, forms both discriminants and
// classifies each equation before handing the item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qfct_front #(
  parameter int unsigned DATA_WIDTH = qfct_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [DATA_WIDTH-1:0]   coef_quad_i,
  input  wire logic signed [DATA_WIDTH-1:0]   coef_lin_i,
  input  wire logic signed [DATA_WIDTH-1:0]   const_upper_i,
  input  wire logic signed [DATA_WIDTH-1:0]   const_lower_i,
  input  wire logic                           full_i,
  output logic                                push_o,
  output logic [DATA_WIDTH-1:0]               amag_o,
  output logic [DATA_WIDTH-1:0]               bmag_o,
  output logic [DATA_WIDTH-1:0]               kmag_u_o,
  output logic [DATA_WIDTH-1:0]               kmag_l_o,
  output logic [2*DATA_WIDTH+1:0]             disc_u_o,
  output logic [2*DATA_WIDTH+1:0]             disc_l_o,
  output qfct_pkg::eq_ctl_t                   ctl_u_o,
  output qfct_pkg::eq_ctl_t                   ctl_l_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned DW = 2 * W + 2;

  logic         en;
  logic         acc;

  // sign/magnitude of the raw inputs
  logic [W-1:0] a_raw, b_raw, ku_raw, kl_raw;
  logic [W-1:0] a_mag, b_mag;
  logic [W-1:0] k_mag [2];
  logic         a_neg, b_neg;
  logic         k_neg [2];

  // stage 1
  logic         v1_q;
  logic [W-1:0] a1_q, b1_q;
  logic         bn1_q;
  logic [W-1:0] k1_q [2];
  logic         kn1_q [2];

  // stage 2
  logic            v2_q;
  logic [W-1:0]    a2_q, b2_q;
  logic            bn2_q;
  logic [W-1:0]    k2_q [2];
  logic            kn2_q [2];
  logic [2*W-1:0]  bsq_q;
  logic [DW-1:0]   ac4_q [2];
  logic [2*W-1:0]  bsq_d;
  logic [2*W-1:0]  ak_d [2];

  logic [DW-1:0]       disc [2];
  qfct_pkg::eq_ctl_t   ctl [2];

  // the whole front moves unless its last stage is blocked by the queue
  assign en         = !v2_q || !full_i;
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;
  assign push_o     = v2_q && !full_i;

  assign a_raw  = coef_quad_i;
  assign b_raw  = coef_lin_i;
  assign ku_raw = const_upper_i;
  assign kl_raw = const_lower_i;

  // magnitudes; a negative a flips the signs of b and k
  always_comb begin
    a_neg    = a_raw[W-1];
    a_mag    = a_neg ? (~a_raw + 1'b1) : a_raw;
    b_mag    = b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;
    b_neg    = b_raw[W-1] ^ (a_neg && (b_mag != '0));
    k_mag[0] = ku_raw[W-1] ? (~ku_raw + 1'b1) : ku_raw;
    k_mag[1] = kl_raw[W-1] ? (~kl_raw + 1'b1) : kl_raw;
    k_neg[0] = ku_raw[W-1] ^ (a_neg && (k_mag[0] != '0));
    k_neg[1] = kl_raw[W-1] ^ (a_neg && (k_mag[1] != '0));
  end

  // products for the discriminants
  always_comb begin
    bsq_d   = b1_q * b1_q;
    ak_d[0] = a1_q * k1_q[0];
    ak_d[1] = a1_q * k1_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q     <= a_mag;
      b1_q     <= b_mag;
      bn1_q    <= b_neg;
      k1_q[0]  <= k_mag[0];
      k1_q[1]  <= k_mag[1];
      kn1_q[0] <= k_neg[0];
      kn1_q[1] <= k_neg[1];
      a2_q     <= a1_q;
      b2_q     <= b1_q;
      bn2_q    <= bn1_q;
      k2_q[0]  <= k1_q[0];
      k2_q[1]  <= k1_q[1];
      kn2_q[0] <= kn1_q[0];
      kn2_q[1] <= kn1_q[1];
      bsq_q    <= bsq_d;
      ac4_q[0] <= {ak_d[0], 2'b00};
      ac4_q[1] <= {ak_d[1], 2'b00};
    end
  end

  // discriminant and root choice for each equation
  always_comb begin
    for (int e = 0; e < 2; e++) begin
      logic k_pos;
      logic d_ok;
      k_pos = !kn2_q[e] && (k2_q[e] != '0);
      d_ok  = kn2_q[e] || ({2'b00, bsq_q} >= ac4_q[e]);
      disc[e] = kn2_q[e] ? ({2'b00, bsq_q} + ac4_q[e])
                         : ({2'b00, bsq_q} - ac4_q[e]);
      ctl[e].ok  = 1'b0;
      ctl[e].sel = qfct_pkg::SEL_LIN;
      if (a2_q == '0) begin
        ctl[e].ok = (b2_q != '0) && (k2_q[e] != '0) && (bn2_q != kn2_q[e]);
      end else if (bn2_q && k_pos) begin
        ctl[e].ok  = d_ok;
        ctl[e].sel = qfct_pkg::SEL_SUB;
      end else if (bn2_q) begin
        ctl[e].ok  = d_ok;
        ctl[e].sel = qfct_pkg::SEL_ADD;
      end else if (kn2_q[e]) begin
        ctl[e].ok  = d_ok;
        ctl[e].sel = qfct_pkg::SEL_DIF;
      end
    end
  end

  assign amag_o   = a2_q;
  assign bmag_o   = b2_q;
  assign kmag_u_o = k2_q[0];
  assign kmag_l_o = k2_q[1];
  assign disc_u_o = disc[0];
  assign disc_l_o = disc[1];
  assign ctl_u_o  = ctl[0];
  assign ctl_l_o  = ctl[1];

endmodule

`default_nettype wire

/* src/qfct_sqrt.sv */
// ----------------------------------------------------------------------------
// qfct_sqrt
// Pipelined integer square root, one result bit per stage, with a side
// channel carried along in step.
// ----------------------------------------------------------------------------
`default_nettype none

module qfct_sqrt #(
  parameter int unsigned DATA_WIDTH = qfct_pkg::DATA_WIDTH_DEF,
  parameter int unsigned SB_W       = 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [2*DATA_WIDTH+1:0] rad_i,
  input  wire logic [SB_W-1:0]         side_i,
  output logic      [DATA_WIDTH:0]     root_o,
  output logic      [SB_W-1:0]         side_o
);

  localparam int unsigned DW = 2 * DATA_WIDTH + 2;
  localparam int unsigned SW = DATA_WIDTH + 1;
  localparam int unsigned RW = SW + 2;

  logic [RW-1:0]   rem_q  [SW];
  logic [SW-1:0]   root_q [SW];
  logic [DW-1:0]   rad_q  [SW];
  logic [SB_W-1:0] side_q [SW];

  for (genvar s = 0; s < SW; s++) begin : g_stg
    logic [RW-1:0]   rem_in, rem_t, trial;
    logic [SW-1:0]   root_in;
    logic [DW-1:0]   rad_in;
    logic [SB_W-1:0] sb_in;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign sb_in   = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign sb_in   = side_q[s-1];
    end

    // bring down two radicand bits and try the next root bit
    assign rem_t = {rem_in[RW-3:0], rad_in[DW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? (rem_t - trial) : rem_t;
        root_q[s] <= {root_in[SW-2:0], ge};
        rad_q[s]  <= {rad_in[DW-3:0], 2'b00};
        side_q[s] <= sb_in;
      end
    end
  end

  assign root_o = root_q[SW-1];
  assign side_o = side_q[SW-1];

endmodule

`default_nettype wire

/* src/qfct_div.sv */
// ----------------------------------------------------------------------------
// qfct_div
// Pipelined restoring divider for floor(num * 2^FRAC_BITS / den), one
// quotient bit per stage, clamping quotients past the output range.
// ----------------------------------------------------------------------------
`default_nettype none

module qfct_div #(
  parameter int unsigned DATA_WIDTH = qfct_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = qfct_pkg::FRAC_BITS_DEF,
  parameter int unsigned SB_W       = 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [DATA_WIDTH+1:0]   num_i,
  input  wire logic [DATA_WIDTH:0]     den_i,
  input  wire logic [SB_W-1:0]         side_i,
  output logic      [DATA_WIDTH-1:0]   quot_o,
  output logic                         sat_o,
  output logic      [SB_W-1:0]         side_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned NW  = W + 2;
  localparam int unsigned DNW = W + 1;
  localparam int unsigned QW  = NW + FRAC_BITS;

  logic [QW-1:0]   dvd_q  [QW];
  logic [DNW-1:0]  rem_q  [QW];
  logic [DNW-1:0]  den_q  [QW];
  logic [W-1:0]    q_q    [QW];
  logic            sat_q  [QW];
  logic [SB_W-1:0] side_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stg
    // quotient bits above the output width only raise the clamp
    localparam bit HIGH_BIT = (s < QW - W);
    logic [QW-1:0]   dvd_in;
    logic [DNW-1:0]  rem_in, den_in;
    logic [W-1:0]    q_in;
    logic            sat_in, ge;
    logic [SB_W-1:0] sb_in;
    logic [DNW:0]    rem_t, dsub;

    if (s == 0) begin : g_first
      assign dvd_in = {num_i, FRAC_BITS'(0)};
      assign rem_in = '0;
      assign den_in = den_i;
      assign q_in   = '0;
      assign sat_in = 1'b0;
      assign sb_in  = side_i;
    end else begin : g_next
      assign dvd_in = dvd_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign q_in   = q_q[s-1];
      assign sat_in = sat_q[s-1];
      assign sb_in  = side_q[s-1];
    end

    assign rem_t = {rem_in, dvd_in[QW-1]};
    assign ge    = (rem_t >= {1'b0, den_in});
    assign dsub  = rem_t - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[s]  <= {dvd_in[QW-2:0], 1'b0};
        rem_q[s]  <= ge ? dsub[DNW-1:0] : rem_t[DNW-1:0];
        den_q[s]  <= den_in;
        q_q[s]    <= {q_in[W-2:0], ge};
        sat_q[s]  <= sat_in | (ge & HIGH_BIT);
        side_q[s] <= sb_in;
      end
    end
  end

  assign quot_o = sat_q[QW-1] ? '1 : q_q[QW-1];
  assign sat_o  = sat_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

`default_nettype wire

/* src/qfct_back.sv */
// ----------------------------------------------------------------------------
// qfct_back
// Takes classified items from the queue, runs square root and divide for
// both equations, picks the earlier root and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qfct_back #(
  parameter int unsigned DATA_WIDTH = qfct_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = qfct_pkg::FRAC_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    empty_i,
  output logic                         pop_o,
  input  wire logic [DATA_WIDTH-1:0]   amag_i,
  input  wire logic [DATA_WIDTH-1:0]   bmag_i,
  input  wire logic [DATA_WIDTH-1:0]   kmag_u_i,
  input  wire logic [DATA_WIDTH-1:0]   kmag_l_i,
  input  wire logic [2*DATA_WIDTH+1:0] disc_u_i,
  input  wire logic [2*DATA_WIDTH+1:0] disc_l_i,
  input  wire qfct_pkg::eq_ctl_t       ctl_u_i,
  input  wire qfct_pkg::eq_ctl_t       ctl_l_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         found_o,
  output logic [DATA_WIDTH-1:0]        crossing_time_o,
  output logic                         saturated_o
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned DW   = 2 * W + 2;
  localparam int unsigned SW   = W + 1;
  localparam int unsigned NW   = W + 2;
  localparam int unsigned CTLW = $bits(qfct_pkg::eq_ctl_t);
  localparam int unsigned SBW  = 3 * W + CTLW;
  localparam int unsigned LAT  = SW + NW + FRAC_BITS;

  logic           en;
  logic [LAT-1:0] vld_q;

  logic [DW-1:0]     disc  [2];
  logic [W-1:0]      kmag  [2];
  qfct_pkg::eq_ctl_t ctl   [2];
  logic [W-1:0]      quot  [2];
  logic              sat   [2];
  logic              fnd   [2];

  logic          pick_l;
  logic          out_valid_q;
  logic          found_q, found_d;
  logic [W-1:0]  time_q, time_d;
  logic          sat_q, sat_d;

  // back end runs while the output register is free or being drained
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && !empty_i;

  assign disc[0] = disc_u_i;
  assign disc[1] = disc_l_i;
  assign kmag[0] = kmag_u_i;
  assign kmag[1] = kmag_l_i;
  assign ctl[0]  = ctl_u_i;
  assign ctl[1]  = ctl_l_i;

  for (genvar e = 0; e < 2; e++) begin : g_eq
    logic [SW-1:0]     root;
    logic [SBW-1:0]    sq_side;
    logic [W-1:0]      sa, sb, sk;
    qfct_pkg::eq_ctl_t sctl;
    logic [NW-1:0]     num;
    logic [W:0]        den;
    logic [0:0]        ok_out;

    qfct_sqrt #(
      .DATA_WIDTH (W),
      .SB_W       (SBW)
    ) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (disc[e]),
      .side_i ({amag_i, bmag_i, kmag[e], ctl[e]}),
      .root_o (root),
      .side_o (sq_side)
    );

    assign {sa, sb, sk, sctl} = sq_side;

    // numerator and denominator for the chosen root
    always_comb begin
      unique case (sctl.sel)
        qfct_pkg::SEL_LIN: begin
          num = {2'b00, sk};
          den = {1'b0, sb};
        end
        qfct_pkg::SEL_SUB: begin
          num = {2'b00, sb} - {1'b0, root};
          den = {sa, 1'b0};
        end
        qfct_pkg::SEL_ADD: begin
          num = {2'b00, sb} + {1'b0, root};
          den = {sa, 1'b0};
        end
        qfct_pkg::SEL_DIF: begin
          num = {1'b0, root} - {2'b00, sb};
          den = {sa, 1'b0};
        end
        default: begin
          num = '0;
          den = '0;
        end
      endcase
    end

    qfct_div #(
      .DATA_WIDTH (W),
      .FRAC_BITS  (FRAC_BITS),
      .SB_W       (1)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num),
      .den_i  (den),
      .side_i (sctl.ok),
      .quot_o (quot[e]),
      .sat_o  (sat[e]),
      .side_o (ok_out)
    );

    assign fnd[e] = ok_out[0];
  end

  // earlier root wins, upper level on a tie
  always_comb begin
    pick_l  = fnd[1] && (!fnd[0] || (quot[1] < quot[0]));
    found_d = fnd[0] || fnd[1];
    if (pick_l) begin
      time_d = quot[1];
      sat_d  = sat[1];
    end else if (fnd[0]) begin
      time_d = quot[0];
      sat_d  = sat[0];
    end else begin
      time_d = '0;
      sat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[LAT-2:0], pop_o};
      out_valid_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      found_q <= found_d;
      time_q  <= time_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign crossing_time_o = time_q;
  assign saturated_o     = sat_q;

`ifndef SYNTHESIS
  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (time_q == '0 && !sat_q))
    else $error("no root but nonzero time or clamp flag");
  a_sat_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && sat_q) |-> (found_q && time_q == '1))
    else $error("clamped result is not all ones");
  a_pop_only_when_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o)
    else $error("queue read while back end is held");
`endif

endmodule

`default_nettype wire

/* src/quadratic_first_crossing_time_top.sv */
// ----------------------------------------------------------------------------
// quadratic_first_crossing_time_top
// Earliest strictly positive root of a*t^2 + b*t + k = 0 over two constant
// terms; signed Q16.16 inputs, unsigned Q16.16 time, found flag, range clamp.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  in      | in_valid_i  | in_stall_o  | coef_quad_i coef_lin_i const_upper_i
//          |             |             | const_lower_i
//  out     | out_valid_o | out_stall_i | found_o crossing_time_o saturated_o
//
//  One item per cycle sustained while the output is not stalled. Items pass
//  through 2 front stages, the queue, DATA_WIDTH+1 square root stages,
//  DATA_WIDTH+2+FRAC_BITS divider stages and the output register.
//  Reset clears the valid bits, queue pointers and output valid; no sweep.
//  An output stall holds the back end; the queue then fills and the front
//  stalls its input once its last stage cannot enter the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_first_crossing_time_top #(
  parameter int unsigned DATA_WIDTH  = qfct_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = qfct_pkg::FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = qfct_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [DATA_WIDTH-1:0] coef_quad_i,
  input  wire logic signed [DATA_WIDTH-1:0] coef_lin_i,
  input  wire logic signed [DATA_WIDTH-1:0] const_upper_i,
  input  wire logic signed [DATA_WIDTH-1:0] const_lower_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              found_o,
  output logic [DATA_WIDTH-1:0]             crossing_time_o,
  output logic                              saturated_o
);

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned DW    = 2 * W + 2;
  localparam int unsigned CTLW  = $bits(qfct_pkg::eq_ctl_t);
  localparam int unsigned ENT_W = 4 * W + 2 * DW + 2 * CTLW;

  logic push, pop, full, empty;

  logic [W-1:0]      f_amag, f_bmag, f_ku, f_kl;
  logic [DW-1:0]     f_du, f_dl;
  qfct_pkg::eq_ctl_t f_cu, f_cl;

  logic [W-1:0]      b_amag, b_bmag, b_ku, b_kl;
  logic [DW-1:0]     b_du, b_dl;
  qfct_pkg::eq_ctl_t b_cu, b_cl;

  logic [ENT_W-1:0] wr_data, rd_data;

  qfct_front #(
    .DATA_WIDTH (W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .coef_quad_i   (coef_quad_i),
    .coef_lin_i    (coef_lin_i),
    .const_upper_i (const_upper_i),
    .const_lower_i (const_lower_i),
    .full_i        (full),
    .push_o        (push),
    .amag_o        (f_amag),
    .bmag_o        (f_bmag),
    .kmag_u_o      (f_ku),
    .kmag_l_o      (f_kl),
    .disc_u_o      (f_du),
    .disc_l_o      (f_dl),
    .ctl_u_o       (f_cu),
    .ctl_l_o       (f_cl)
  );

  assign wr_data = {f_amag, f_bmag, f_ku, f_kl, f_du, f_dl, f_cu, f_cl};

  qfct_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (wr_data),
    .pop_i     (pop),
    .rd_data_o (rd_data),
    .full_o    (full),
    .empty_o   (empty)
  );

  assign {b_amag, b_bmag, b_ku, b_kl, b_du, b_dl, b_cu, b_cl} = rd_data;

  qfct_back #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .pop_o           (pop),
    .amag_i          (b_amag),
    .bmag_i          (b_bmag),
    .kmag_u_i        (b_ku),
    .kmag_l_i        (b_kl),
    .disc_u_i        (b_du),
    .disc_l_i        (b_dl),
    .ctl_u_i         (b_cu),
    .ctl_l_i         (b_cl),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .crossing_time_o (crossing_time_o),
    .saturated_o     (saturated_o)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quadratic_first_crossing_time_top. Requests are
// driven with random gaps, results are taken with random stalls. Every
// accepted request is predicted with exact wide integer arithmetic and the
// prediction is queued. Each result is compared in order with the queue.
// ----------------------------------------------------------------------------

module testbench;

  localparam int DW        = qfct_pkg::DATA_WIDTH_DEF;
  localparam int FB        = qfct_pkg::FRAC_BITS_DEF;
  localparam int N_RANDOM  = 1530;
  localparam int WD_LIMIT  = 5000;
  localparam int DRAIN_CYC = 200;

  typedef logic signed [DW-1:0] coef_t;

  typedef struct {
    logic          found;
    logic [DW-1:0] t;
    logic          sat;
  } crossing_t;

  // --------------------------------------------------------------------------
  // expected-crossing store and predictor
  class crossing_board;
    crossing_t pending[$];
    int        errors;
    int        checked;
    int        n_found;
    int        n_sat;

    // smallest positive root of a*t^2 + b*t + k, clamped
    function automatic crossing_t root_of(coef_t a, coef_t b, coef_t k);
      crossing_t   r;
      logic [63:0] am, bm, km, s, num, den, cand;
      logic        an, bn, kn, kpos;
      logic [127:0] bsq, ac4, disc, quot;
      r = '{found: 1'b0, t: '0, sat: 1'b0};
      am = a[DW-1] ? 64'(-$signed(65'(a))) : 64'(a);
      bm = b[DW-1] ? 64'(-$signed(65'(b))) : 64'(b);
      km = k[DW-1] ? 64'(-$signed(65'(k))) : 64'(k);
      an = a[DW-1];
      bn = b[DW-1];
      kn = k[DW-1];
      if (am == 0) begin
        if (bm == 0 || km == 0 || bn == kn) return r;
        num = km;
        den = bm;
      end else begin
        // make a positive, flipping b and k with it
        if (an) begin
          if (bm != 0) bn = !bn;
          if (km != 0) kn = !kn;
        end
        kpos = !kn && km != 0;
        bsq  = 128'(bm) * 128'(bm);
        ac4  = 128'(am) * 128'(km << 2);
        if (kn) disc = bsq + ac4;
        else begin
          if (bsq < ac4) return r;
          disc = bsq - ac4;
        end
        s = '0;
        for (int i = 63; i >= 0; i--) begin
          cand = s | (64'd1 << i);
          if (128'(cand) * 128'(cand) <= disc) s = cand;
        end
        if (bn && kpos) num = bm - s;
        else if (bn) num = bm + s;
        else if (kn) num = s - bm;
        else return r;
        den = am << 1;
      end
      quot    = (128'(num) << FB) / 128'(den);
      r.found = 1'b1;
      if (quot > 128'({DW{1'b1}})) begin
        r.t   = '1;
        r.sat = 1'b1;
      end else r.t = quot[DW-1:0];
      return r;
    endfunction

    function void note_request(coef_t a, coef_t b, coef_t ku, coef_t kl);
      crossing_t up, lo, r;
      up = root_of(a, b, ku);
      lo = root_of(a, b, kl);
      if (up.found && lo.found) begin
        if (lo.t < up.t) r = lo;
        else r = up;
      end else if (up.found) r = up;
      else r = lo;
      pending = {pending, r};
    endfunction

    function void check_result(logic found, logic [DW-1:0] t, logic sat);
      crossing_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: found=%0b t=%h", found, t);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.found) n_found++;
      if (e.sat) n_sat++;
      if (found !== e.found) begin
        $error("found: expected %0b, got %0b", e.found, found);
        errors++;
      end
      if (t !== e.t) begin
        $error("crossing_time: expected %h, got %h", e.t, t);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated: expected %0b, got %0b", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  coef_t         coef_quad_i, coef_lin_i, const_upper_i, const_lower_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic          found_o;
  logic [DW-1:0] crossing_time_o;
  logic          saturated_o;

  crossing_board board;
  bit            no_gaps;
  bit            no_stalls;
  int            stall_left;
  int            idle_cycles;

  quadratic_first_crossing_time_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .coef_quad_i    (coef_quad_i),
    .coef_lin_i     (coef_lin_i),
    .const_upper_i  (const_upper_i),
    .const_lower_i  (const_lower_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .crossing_time_o(crossing_time_o),
    .saturated_o    (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // monitors: requests in, results out
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      board.note_request(coef_quad_i, coef_lin_i, const_upper_i, const_lower_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(found_o, crossing_time_o, saturated_o);
  end

  // output stall: a fresh random wait after each result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        stall_left = no_stalls ? 0 : $urandom_range(0, 15);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WD_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one request after a random gap; valid stays high into a zero gap
  task automatic send_request(coef_t a, coef_t b, coef_t ku, coef_t kl);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    coef_quad_i   <= a;
    coef_lin_i    <= b;
    const_upper_i <= ku;
    const_lower_i <= kl;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  // coefficient mix: full range, small, zero and extremes
  function automatic coef_t pick_coef();
    case ($urandom_range(0, 9))
      0, 1, 2: return coef_t'($urandom);
      3:       return '0;
      4:       return $urandom_range(0, 1) ? coef_t'(32'h8000_0000)
                                           : coef_t'(32'h7fff_ffff);
      5:       return coef_t'($urandom_range(0, 8)) - 4;
      default: return coef_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  localparam coef_t MINV = 32'sh8000_0000;
  localparam coef_t MAXV = 32'sh7fff_ffff;
  localparam coef_t ONE  = 32'sh0001_0000;

  initial begin
    coef_t a, b, ku;
    board         = new();
    no_gaps       = 0;
    no_stalls     = 0;
    stall_left    = 0;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    out_stall_i   = 1'b0;
    coef_quad_i   = '0;
    coef_lin_i    = '0;
    const_upper_i = '0;
    const_lower_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: linear, degenerate, discriminant, sign and range corners
    send_request('0, '0, '0, '0);
    send_request('0, '0, ONE, -ONE);
    send_request('0, ONE, -ONE, ONE);
    send_request('0, -ONE, 2 * ONE, -ONE);
    send_request('0, 32'sd1, MINV, MAXV);
    send_request('0, MINV, MAXV, MINV);
    send_request(ONE, '0, ONE, 2 * ONE);
    send_request(ONE, '0, -ONE, -4 * ONE);
    send_request(ONE, -4 * ONE, 3 * ONE, 5 * ONE);
    send_request(ONE, -2 * ONE, ONE, ONE);
    send_request(-ONE, ONE, ONE, -ONE);
    send_request(-ONE, -ONE, -ONE, 2 * ONE);
    send_request(ONE, ONE, ONE, 2 * ONE);
    send_request(32'sd1, '0, -ONE, MINV);
    send_request(MAXV, MAXV, MINV, MAXV);
    send_request(MINV, MINV, MINV, MAXV);
    send_request(MINV, MAXV, MAXV, MINV);
    send_request(MAXV, -32'sd1, 32'sd1, -32'sd1);
    send_request(MAXV, '0, -32'sd1, 32'sd1);
    send_request(ONE, '0, '0, -ONE);
    send_request(-1, -1, -1, -1);
    send_request(ONE, -ONE, 32'sd1, 32'sd1);

    // hold off until every directed result is back
    wait_drained();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 200 == 0) begin
        no_gaps   = ($urandom_range(0, 3) == 0);
        no_stalls = ($urandom_range(0, 3) == 0);
      end
      a  = pick_coef();
      b  = pick_coef();
      ku = pick_coef();
      // sometimes equal constants, to force ties
      send_request(a, b, ku, ($urandom_range(0, 15) == 0) ? ku : pick_coef());
    end
    no_stalls = 1;
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Checked %0d results: %0d with a crossing, %0d clamped.",
             board.checked, board.n_found, board.n_sat);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
